/* hw/rtl/brqs_pkg.sv */
// Package with types, constants and codes shared by the burst run queue scheduler.
`default_nettype none

package brqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;

    localparam int THREAD_W = 4;
    localparam int BURST_W  = 16;
    localparam int LENGTH_W = 16;
    localparam int CLOCK_W  = 20;
    localparam int GAP_W    = 16;

    // virtual runtime: floor(length * (7 + 3*thread) / 10)
    localparam int FACTOR_W = 6;
    localparam int PROD_W   = LENGTH_W + FACTOR_W;
    localparam int KEY_W    = 19;
    localparam int RECIP_SH = 26;
    localparam int RECIP_W  = 23;
    localparam logic [RECIP_W-1:0] RECIP_DIV10 = 23'd6710887;

    typedef enum logic [1:0] {
        POL_FCFS   = 2'd0,
        POL_SJF    = 2'd1,
        POL_PRIO   = 2'd2,
        POL_VRTIME = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        STAT_ENQ   = 2'd0,
        STAT_DEQ   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef struct packed {
        logic [THREAD_W-1:0] thread;
        logic [BURST_W-1:0]  burst;
        logic [LENGTH_W-1:0] length;
        logic [CLOCK_W-1:0]  clock;
        logic [GAP_W-1:0]    gap;
        logic [KEY_W-1:0]    vkey;
    } slot_t;

    // running minimum handed from cell to cell during a scan
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
        slot_t            slot;
    } token_t;

    typedef struct packed {
        logic occupied;
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/burst_run_queue_scheduler.sv */
// Top level of the burst run queue scheduler: control, cell chain and stream ports.
`default_nettype none

// Bounded run queue of CPU bursts held in arrival order in a chain of
// QUEUE_DEPTH cells, cell 0 the oldest. An input transfer with s_tuser
// low enqueues the burst in s_tdata; with s_tuser high it removes the
// entry chosen by the policy register (0 oldest, 1 least length,
// 2 least thread id, 3 least floor(length*(7+3*thread)/10)), the oldest
// entry winning ties, and the younger entries close up the gap. Each
// item yields exactly one output transfer carrying a status in m_tuser
// (0 enqueued, 1 dequeued, 2 full and dropped, 3 empty) and the removed
// burst plus the occupancy after the operation in m_tdata; burst fields
// read zero unless the status is 1. One item is processed at a time:
// an enqueue first passes the two-stage virtual runtime key pipeline;
// a dequeue waits for the minimum token walking one cell per cycle
// down the chain; a full or empty report needs neither. The result
// register lets the next item be accepted while a result waits. The
// policy is written on the cfg channel, always ready; the user must
// write it only while idle, which the block itself does not enforce.
module burst_run_queue_scheduler
    import brqs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel: [1:0] policy
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: [3:0] thread_id, [19:4] burst_id, [35:20] length,
    //          [55:36] wall_clock, [71:56] arrival_gap
    input  wire logic [71:0] s_tdata,
    // s_tuser: [0] cmd
    input  wire logic        s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: [3:0] out_thread, [19:4] out_burst, [35:20] out_length,
    //          [55:36] out_clock, [71:56] out_gap, [76:72] occupancy,
    //          [79:77] zero
    output logic [79:0]      m_tdata,
    // m_tuser: [1:0] status
    output logic [1:0]       m_tuser
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    policy_t          policy_reg;
    status_t          op_reg, op_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             scan_start_reg, scan_start_next;
    slot_t            in_reg;
    slot_t            load_slot;
    logic [IDX_W-1:0] pick_reg;
    slot_t            taken_reg;
    logic [KEY_W-1:0] vkey;

    logic             m_valid_reg;
    status_t          m_status_reg;
    slot_t            m_slot_reg;
    logic [OCC_W-1:0] m_occ_reg;

    logic             in_xfer;
    logic             out_free;
    logic             commit;

    token_t           tok_chain [QUEUE_DEPTH+1];
    slot_t            slot_chain [QUEUE_DEPTH+1];
    cell_ctrl_t       ctrl [QUEUE_DEPTH];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign commit    = (state_reg == ST_FINISH) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_FCFS;
        end else if (cfg_valid && cfg_ready) begin
            policy_reg <= policy_t'(cfg_data);
        end
    end

    // hold the accepted burst for the key pipeline and the load
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_reg.thread <= s_tdata[3:0];
            in_reg.burst  <= s_tdata[19:4];
            in_reg.length <= s_tdata[35:20];
            in_reg.clock  <= s_tdata[55:36];
            in_reg.gap    <= s_tdata[71:56];
            in_reg.vkey   <= '0;
        end
    end

    brqs_vkey u_vkey (
        .aclk   (aclk),
        .thread (in_reg.thread),
        .length (in_reg.length),
        .vkey   (vkey)
    );

    always_comb begin
        load_slot      = in_reg;
        load_slot.vkey = vkey;
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        scan_start_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == CMD_ENQ) begin
                        if (count_reg >= CNT_W'(QUEUE_DEPTH)) begin
                            op_next    = STAT_FULL;
                            state_next = ST_FINISH;
                        end else begin
                            op_next    = STAT_ENQ;
                            state_next = ST_MUL;
                        end
                    end else if (count_reg == '0) begin
                        op_next    = STAT_EMPTY;
                        state_next = ST_FINISH;
                    end else begin
                        op_next         = STAT_DEQ;
                        scan_start_next = 1'b1;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_FINISH;
            ST_SCAN: begin
                if (tok_chain[QUEUE_DEPTH].valid) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    case (op_reg)
                        STAT_ENQ: count_next = count_reg + CNT_W'(1);
                        STAT_DEQ: count_next = count_reg - CNT_W'(1);
                        default:  count_next = count_reg;
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            scan_start_reg <= 1'b0;
            op_reg         <= STAT_ENQ;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_start_reg <= scan_start_next;
            op_reg         <= op_next;
        end
    end

    // capture the winner as the token leaves the last cell
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_SCAN) && tok_chain[QUEUE_DEPTH].valid) begin
            pick_reg  <= tok_chain[QUEUE_DEPTH].idx;
            taken_reg <= tok_chain[QUEUE_DEPTH].slot;
        end
    end

    // inject a fresh token at the head of the chain
    always_comb begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = scan_start_reg;
    end

    assign slot_chain[QUEUE_DEPTH] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        always_comb begin
            ctrl[i].occupied = (CNT_W'(i) < count_reg);
            ctrl[i].load     = commit && (op_reg == STAT_ENQ) && (CNT_W'(i) == count_reg);
            // close up: each cell from the removed one up to the second youngest takes its younger neighbor
            ctrl[i].shift    = commit && (op_reg == STAT_DEQ)
                               && (IDX_W'(i) >= pick_reg)
                               && (CNT_W'(i + 1) < count_reg);
        end

        brqs_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .policy    (policy_reg),
            .ctrl      (ctrl[i]),
            .my_idx    (IDX_W'(i)),
            .load_slot (load_slot),
            .next_slot (slot_chain[i+1]),
            .tok_in    (tok_chain[i]),
            .tok_out   (tok_chain[i+1]),
            .slot_out  (slot_chain[i])
        );
    end

    // result register: advance on commit, drop valid once the transfer is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_status_reg <= op_reg;
            m_occ_reg    <= OCC_W'(count_next);
            if (op_reg == STAT_DEQ) begin
                m_slot_reg <= taken_reg;
            end else begin
                m_slot_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_occ_reg, m_slot_reg.gap, m_slot_reg.clock,
                       m_slot_reg.length, m_slot_reg.burst, m_slot_reg.thread};

endmodule

`default_nettype wire

/* hw/rtl/brqs_vkey.sv */
// Two-stage pipeline computing the virtual runtime key of a burst.
`default_nettype none

module brqs_vkey
    import brqs_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic [THREAD_W-1:0] thread,
    input  wire logic [LENGTH_W-1:0] length,
    output logic      [KEY_W-1:0]    vkey
);

    logic [FACTOR_W-1:0]        factor;
    logic [PROD_W-1:0]          prod_reg;
    logic [PROD_W+RECIP_W-1:0]  scaled;
    logic [KEY_W-1:0]           vkey_reg;

    assign factor = FACTOR_W'(7) + FACTOR_W'(3) * {{(FACTOR_W-THREAD_W){1'b0}}, thread};
    // divide by ten through the reciprocal; exact for every product below 2^22
    assign scaled = {{RECIP_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, RECIP_DIV10};

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(length) * PROD_W'(factor);
        vkey_reg <= scaled[RECIP_SH +: KEY_W];
    end

    assign vkey = vkey_reg;

endmodule

`default_nettype wire

/* hw/rtl/brqs_cell.sv */
// One queue cell: holds an entry, updates the scan token, shifts toward the head.
`default_nettype none

module brqs_cell
    import brqs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire policy_t          policy,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [IDX_W-1:0] my_idx,
    input  wire slot_t            load_slot,
    input  wire slot_t            next_slot,
    input  wire token_t           tok_in,
    output token_t                tok_out,
    output slot_t                 slot_out
);

    slot_t            slot_reg;
    token_t           tok_reg;
    token_t           tok_next;
    logic [KEY_W-1:0] key;
    logic             take;

    always_comb begin
        case (policy)
            POL_FCFS:   key = '0;
            POL_SJF:    key = KEY_W'(slot_reg.length);
            POL_PRIO:   key = KEY_W'(slot_reg.thread);
            POL_VRTIME: key = slot_reg.vkey;
            default:    key = '0;
        endcase
    end

    // strict compare keeps the older entry on a tie
    assign take = ctrl.occupied && (!tok_in.found || (key < tok_in.key));

    always_comb begin
        tok_next = tok_in;
        if (take) begin
            tok_next.found = 1'b1;
            tok_next.key   = key;
            tok_next.idx   = my_idx;
            tok_next.slot  = slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            slot_reg <= load_slot;
        end else if (ctrl.shift) begin
            slot_reg <= next_slot;
        end
    end

    assign tok_out  = tok_reg;
    assign slot_out = slot_reg;

endmodule

`default_nettype wire

/* dv/brqs_checker.sv */
// Checker for the burst run queue scheduler: watches all channels, predicts and compares results.
`timescale 1ns / 1ps

module brqs_checker
    import brqs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [79:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    output int               fail_count,
    output int               results_due,
    output int               enq_seen,
    output int               deq_seen,
    output int               full_seen,
    output int               empty_seen
);

    // field order mirrors the wire layout: thread in the lowest bits
    typedef struct packed {
        logic [GAP_W-1:0]    gap;
        logic [CLOCK_W-1:0]  clock;
        logic [LENGTH_W-1:0] length;
        logic [BURST_W-1:0]  burst;
        logic [THREAD_W-1:0] thread;
    } burst_entry_t;

    typedef struct packed {
        status_t          status;
        burst_entry_t     entry;
        logic [OCC_W-1:0] occupancy;
    } sched_result_t;

    burst_entry_t  run_queue [QUEUE_DEPTH];
    int            held;
    policy_t       policy;
    sched_result_t expected_results [$];

    initial begin
        fail_count  = 0;
        results_due = 0;
        enq_seen    = 0;
        deq_seen    = 0;
        full_seen   = 0;
        empty_seen  = 0;
        held        = 0;
        policy      = POL_FCFS;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 25)
            $display("[%0t] mismatch, %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic logic [31:0] selection_key(burst_entry_t e, policy_t rule);
        case (rule)
            POL_SJF:    return 32'(e.length);
            POL_PRIO:   return 32'(e.thread);
            POL_VRTIME: return (32'(e.length) * (32'd7 + 32'd3 * 32'(e.thread))) / 32'd10;
            default:    return 32'd0;
        endcase
    endfunction

    // apply one command to the predicted queue and return its result
    function automatic sched_result_t run_queue_step(logic cmd, burst_entry_t item);
        sched_result_t r;
        int            pick;
        logic [31:0]   best;
        logic [31:0]   k;
        r = '0;
        if (cmd == CMD_ENQ) begin
            if (held >= QUEUE_DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                run_queue[held] = item;
                held++;
                r.status = STAT_ENQ;
            end
        end else if (held == 0) begin
            r.status = STAT_EMPTY;
        end else begin
            pick = 0;
            best = selection_key(run_queue[0], policy);
            for (int i = 1; i < held; i++) begin
                k = selection_key(run_queue[i], policy);
                if (k < best) begin
                    best = k;
                    pick = i;
                end
            end
            r.entry = run_queue[pick];
            for (int i = pick; i < held - 1; i++)
                run_queue[i] = run_queue[i + 1];
            held--;
            r.status = STAT_DEQ;
        end
        r.occupancy = OCC_W'(held);
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        sched_result_t want;
        burst_entry_t  got;
        if (!aresetn) begin
            held   = 0;
            policy = POL_FCFS;
            expected_results.delete();
        end else begin
            // results first: nothing accepted at this edge can answer at it
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with nothing expected", 32'(m_tuser), 0);
                end else begin
                    want = expected_results.pop_front();
                    got  = burst_entry_t'(m_tdata[71:0]);
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (got.thread !== want.entry.thread)
                        report_mismatch("out_thread", 32'(got.thread), 32'(want.entry.thread));
                    if (got.burst !== want.entry.burst)
                        report_mismatch("out_burst", 32'(got.burst), 32'(want.entry.burst));
                    if (got.length !== want.entry.length)
                        report_mismatch("out_length", 32'(got.length), 32'(want.entry.length));
                    if (got.clock !== want.entry.clock)
                        report_mismatch("out_clock", 32'(got.clock), 32'(want.entry.clock));
                    if (got.gap !== want.entry.gap)
                        report_mismatch("out_gap", 32'(got.gap), 32'(want.entry.gap));
                    if (m_tdata[76:72] !== want.occupancy)
                        report_mismatch("occupancy", 32'(m_tdata[76:72]), 32'(want.occupancy));
                    if (m_tdata[79:77] !== 3'b000)
                        report_mismatch("tdata padding", 32'(m_tdata[79:77]), 0);
                    case (want.status)
                        STAT_ENQ:  enq_seen++;
                        STAT_DEQ:  deq_seen++;
                        STAT_FULL: full_seen++;
                        default:   empty_seen++;
                    endcase
                end
            end
            if (cfg_valid && cfg_ready)
                policy = policy_t'(cfg_data);
            if (s_tvalid && s_tready)
                expected_results.push_back(run_queue_step(s_tuser, burst_entry_t'(s_tdata)));
        end
        results_due = expected_results.size();
    end

endmodule

/* dv/burst_run_queue_scheduler_test.sv */
// Testbench top for the burst run queue scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module burst_run_queue_scheduler_test
    import brqs_pkg::*;
();

    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASES       = 8;
    localparam int CHUNK        = 40;
    localparam int HOLD_CYCLES  = 90;
    // longest item is a dequeue scan; keep some margin
    localparam int DRAIN_CYCLES = QUEUE_DEPTH + 12;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum {RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_PATTERN} rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    // s_tdata: [3:0] thread_id, [19:4] burst_id, [35:20] length,
    //          [55:36] wall_clock, [71:56] arrival_gap
    logic [71:0] s_tdata;
    // s_tuser: [0] cmd
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // m_tdata: [3:0] out_thread, [19:4] out_burst, [35:20] out_length,
    //          [55:36] out_clock, [71:56] out_gap, [76:72] occupancy, [79:77] zero
    logic [79:0] m_tdata;
    // m_tuser: [1:0] status
    logic [1:0]  m_tuser;

    int fail_count;
    int results_due;
    int enq_seen;
    int deq_seen;
    int full_seen;
    int empty_seen;

    int       items_sent    = 0;
    int       policy_writes = 0;
    int       burst_left    = 0;
    bit       sender_gaps   = 1'b1;
    rx_mode_t rx_mode       = RX_ALWAYS;
    int       hold_asked    = 0;
    int       hold_served   = 0;
    int       hold_left     = 0;
    int       rx_step       = 0;
    int       cycle_count   = 0;

    burst_run_queue_scheduler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    brqs_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .results_due (results_due),
        .enq_seen    (enq_seen),
        .deq_seen    (deq_seen),
        .full_seen   (full_seen),
        .empty_seen  (empty_seen)
    );

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Count cycles and end the run if it hangs anywhere.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, results_due);
        $display("burst_run_queue_scheduler_test NOT OK");
        $finish;
    end

    // Result-side backpressure. A long hold-off, counted here, starts whenever the
    // stimulus asks for one; otherwise follow the current stall mode.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            rx_step++;
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_tready <= 1'b1;
                    RX_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
                    RX_SELDOM:  m_tready <= ($urandom_range(0, 3) == 0);
                    default:    m_tready <= 1'(8'b1011_0010 >> (rx_step % 8));
                endcase
            end
        end
    end

    // Pack one burst in tdata order, thread in the low bits.
    function automatic logic [71:0] make_burst(logic [3:0] thread, logic [15:0] burst,
                                               logic [15:0] length, logic [19:0] clock,
                                               logic [15:0] gap);
        return {gap, clock, length, burst, thread};
    endfunction

    // Offer one item and hold it until the transfer. Insert a random gap
    // before each new burst of back-to-back items unless gaps are off.
    task automatic offer_item(input logic cmd, input logic [71:0] burst);
        int idle;
        if (burst_left == 0) begin
            idle = sender_gaps ? $urandom_range(0, 6) : 0;
            if (idle > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (idle - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= burst;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Random burst: lengths often tiny so that ties exercise oldest-wins,
    // clocks now and then beyond 999999.
    task automatic offer_random(input logic cmd);
        logic [15:0] length;
        logic [19:0] clock;
        case ($urandom_range(0, 9))
            0:          length = 16'h0000;
            1:          length = 16'hFFFF;
            2, 3, 4, 5: length = 16'($urandom_range(0, 7));
            default:    length = 16'($urandom);
        endcase
        clock = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(0, 999999));
        offer_item(cmd, make_burst(4'($urandom), 16'($urandom), length, clock,
                                   16'($urandom)));
    endtask

    // Drop valid, wait until every expected result has arrived, then let the
    // block go quiet.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_policy(input policy_t rule);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= rule;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        policy_writes++;
    endtask

    initial begin : stimulus
        policy_t phase_policy [PHASES];
        int      per_phase;
        int      enq_pct;
        phase_policy = '{POL_VRTIME, POL_SJF, POL_PRIO, POL_FCFS,
                         POL_VRTIME, POL_SJF, POL_PRIO, POL_VRTIME};
        per_phase = RANDOM_ITEMS / PHASES;

        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 2'd0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_ENQ;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Directed part, under the reset policy (oldest first).
        // Dequeue on an empty queue.
        offer_item(CMD_DEQ, make_burst(4'hF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF));
        // Fill the queue with field extremes, a wide clock and some tied lengths.
        for (int i = 0; i < QUEUE_DEPTH; i++)
            offer_item(CMD_ENQ, make_burst(
                4'(15 - i),
                i[0] ? 16'hFFFF : 16'(i),
                (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'(500 * (i % 4)),
                (i == 2) ? 20'hFFFFF : (i == 3) ? 20'd999999 : (i == 4) ? 20'd0 : 20'(i * 7),
                i[0] ? 16'hFFFF : 16'h0000));
        // Enqueue on a full queue: drop it.
        offer_item(CMD_ENQ, make_burst(4'h5, 16'h1234, 16'h0001, 20'h00001, 16'h0001));
        repeat (4) offer_item(CMD_DEQ, '0);

        // Random phases, each under its own policy. The queue contents carry over.
        for (int p = 0; p < PHASES; p++) begin
            write_policy(phase_policy[p]);
            rx_mode = rx_mode_t'(p % 4);
            for (int n = 0; n < per_phase; n += CHUNK) begin
                // Drift between filling, balanced and draining to reach full and empty.
                case ($urandom_range(0, 2))
                    0:       enq_pct = 80;
                    1:       enq_pct = 55;
                    default: enq_pct = 25;
                endcase
                sender_gaps = ($urandom_range(0, 3) != 0);
                if (p == 2 && n == 0) begin
                    // Hold off the result side for a long stretch while items keep
                    // coming back to back, so the block backs up into its input.
                    sender_gaps = 1'b0;
                    enq_pct     = 80;
                    hold_asked++;
                end
                for (int j = 0; j < CHUNK && n + j < per_phase; j++)
                    offer_random(($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ);
            end
        end

        rx_mode = RX_ALWAYS;
        settle();

        $display("Sent %0d items across %0d policy writes and all stall modes.",
                 items_sent, policy_writes);
        $display("Results: %0d enqueued, %0d dequeued, %0d dropped when full, %0d empty.",
                 enq_seen, deq_seen, full_seen, empty_seen);
        if (fail_count == 0 && results_due == 0) begin
            $display("burst_run_queue_scheduler_test OK");
        end else begin
            $display("burst_run_queue_scheduler_test NOT OK");
        end
        $finish;
    end

endmodule
